// ----- design/tli_pkg.sv -----
// tli_pkg: shared types, codes and constants for the timelapse intervalometer
// no dependencies
`timescale 1ns / 1ps

package tli_pkg;

   localparam int unsigned DEBOUNCE_W = 8;
   localparam int unsigned SHUTTER_W  = 12;
   localparam int unsigned BLINK_W    = 12;
   localparam int unsigned TPS_W      = 16;
   localparam int unsigned INTERVAL_W = 8;
   localparam int unsigned PHASE_W    = 16;
   localparam int unsigned SECS_W     = 14;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 8'd25;
   localparam logic [SHUTTER_W-1:0]  SHUTTER_RST  = 12'd300;
   localparam logic [BLINK_W-1:0]    BLINK_RST    = 12'd1000;
   localparam logic [TPS_W-1:0]      TPS_RST      = 16'd1000;

   localparam logic [SECS_W-1:0]     SECONDS_MAX  = 14'd16383;
   localparam logic [INTERVAL_W-1:0] PLUS_ONE     = 8'd1;
   localparam logic [INTERVAL_W-1:0] PLUS_TEN     = 8'd10;

   localparam int unsigned MINUTE_SECONDS_DEF = 60;

   typedef enum logic [2:0] {
      MODE_PICK        = 3'd0,
      MODE_SET         = 3'd1,
      MODE_BLINK_START = 3'd2,
      MODE_PULSE       = 3'd3,
      MODE_WAIT        = 3'd4,
      MODE_BLINK_END   = 3'd5
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEBOUNCE = 2'd0,
      CSR_SHUTTER  = 2'd1,
      CSR_BLINK    = 2'd2,
      CSR_TPS      = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic press_first;
      logic press_second;
      logic press_start;
   } req_type;

   typedef struct packed {
      logic                  shutter_out;
      logic                  led_out;
      logic [2:0]            mode_now;
      logic [INTERVAL_W-1:0] interval_now;
      logic                  unit_is_minutes;
   } rsp_type;

   typedef struct packed {
      logic first;
      logic second;
      logic start;
      logic qual;
   } btn_type;

   typedef struct packed {
      logic [DEBOUNCE_W-1:0] debounce_ticks;
      logic [SHUTTER_W-1:0]  shutter_ticks;
      logic [BLINK_W-1:0]    blink_half_ticks;
      logic [TPS_W-1:0]      ticks_per_second;
   } cfg_type;

endpackage

// ----- design/tli_debounce.sv -----
// tli_debounce: press qualifier for one button, with release lockout
// depends on tli_pkg
`timescale 1ns / 1ps

module tli_debounce (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic                           press,
   input  logic [tli_pkg::DEBOUNCE_W-1:0] debounce_ticks,
   output logic                           event_out,
   output logic                           qual_out
);
   import tli_pkg::*;

   logic [DEBOUNCE_W-1:0] count_ff, count_in;
   logic                  hold_ff, hold_in;
   logic [DEBOUNCE_W:0]   count_next;

   assign count_next = {1'b0, count_ff} + 1'b1;

   always_comb begin
      count_in  = count_ff;
      hold_in   = hold_ff;
      event_out = 1'b0;
      qual_out  = 1'b0;
      if (!press) begin
         count_in = '0;
         hold_in  = 1'b0;
      end else if (!hold_ff) begin
         qual_out = 1'b1;
         if (count_next >= {1'b0, debounce_ticks}) begin
            event_out = 1'b1;
            hold_in   = 1'b1;
            count_in  = '0;
         end else begin
            count_in = count_next[DEBOUNCE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         hold_ff  <= 1'b0;
      end else if (step) begin
         count_ff <= count_in;
         hold_ff  <= hold_in;
      end
   end

endmodule

// ----- design/tli_ctrl.sv -----
// tli_ctrl: mode sequencer, interval setting, shutter and wait timing
// depends on tli_pkg; takes qualified button events from tli_debounce
`timescale 1ns / 1ps

module tli_ctrl #(
   parameter int unsigned MINUTE_SECONDS = tli_pkg::MINUTE_SECONDS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  tli_pkg::btn_type btn,
   input  tli_pkg::cfg_type cfg,
   output tli_pkg::rsp_type result
);
   import tli_pkg::*;

   localparam int unsigned MinW  = $clog2(MINUTE_SECONDS + 1);
   localparam int unsigned ProdW = INTERVAL_W + MinW;
   localparam int unsigned FullW = (ProdW > SECS_W) ? ProdW : SECS_W;

   mode_type              mode_ff, mode_in;
   logic                  unit_ff, unit_in;
   logic [INTERVAL_W-1:0] interval_ff, interval_in;
   logic [PHASE_W-1:0]    phase_ff, phase_in;
   logic [SECS_W-1:0]     secs_ff, secs_in;
   logic                  stop_ff, stop_in;

   logic [PHASE_W:0]      phase_next;
   logic [BLINK_W:0]      blink_total;
   logic                  run_mode;
   logic                  stop_mid;
   logic [FullW-1:0]      secs_full;
   logic [SECS_W-1:0]     secs_sat;
   logic                  shutter_q;
   logic                  led_q;

   assign phase_next  = {1'b0, phase_ff} + 1'b1;
   assign blink_total = {cfg.blink_half_ticks, 1'b0};
   assign run_mode    = (mode_ff == MODE_BLINK_START) || (mode_ff == MODE_PULSE) ||
                        (mode_ff == MODE_WAIT);
   assign stop_mid    = stop_ff | (run_mode & btn.start);

   always_comb begin
      if (unit_ff) begin
         secs_full = FullW'(interval_ff) * FullW'(MINUTE_SECONDS);
      end else begin
         secs_full = FullW'(interval_ff);
      end
      if (secs_full > FullW'(SECONDS_MAX)) begin
         secs_sat = SECONDS_MAX;
      end else begin
         secs_sat = secs_full[SECS_W-1:0];
      end
   end

   // next state
   always_comb begin
      mode_in     = mode_ff;
      unit_in     = unit_ff;
      interval_in = interval_ff;
      phase_in    = phase_ff;
      secs_in     = secs_ff;
      stop_in     = stop_mid;
      unique case (mode_ff)
         MODE_PICK: begin
            if (btn.first) begin
               unit_in = 1'b0;
               mode_in = MODE_SET;
            end else if (btn.second) begin
               unit_in = 1'b1;
               mode_in = MODE_SET;
            end
         end
         MODE_SET: begin
            if (btn.start) begin
               mode_in  = MODE_BLINK_START;
               phase_in = '0;
               stop_in  = 1'b0;
            end else begin
               interval_in = interval_ff + (btn.first ? PLUS_ONE : '0)
                                         + (btn.second ? PLUS_TEN : '0);
            end
         end
         MODE_BLINK_START: begin
            if (phase_next >= (PHASE_W+1)'(blink_total)) begin
               phase_in = '0;
               stop_in  = 1'b0;
               mode_in  = stop_mid ? MODE_BLINK_END : MODE_PULSE;
            end else begin
               phase_in = phase_next[PHASE_W-1:0];
            end
         end
         MODE_PULSE: begin
            if (phase_next >= (PHASE_W+1)'(cfg.shutter_ticks)) begin
               phase_in = '0;
               secs_in  = secs_sat;
               if (secs_sat == '0) begin
                  stop_in = 1'b0;
                  mode_in = stop_mid ? MODE_BLINK_END : MODE_PULSE;
               end else begin
                  mode_in = MODE_WAIT;
               end
            end else begin
               phase_in = phase_next[PHASE_W-1:0];
            end
         end
         MODE_WAIT: begin
            if (phase_next >= (PHASE_W+1)'(cfg.ticks_per_second)) begin
               phase_in = '0;
               if (secs_ff <= SECS_W'(1)) begin
                  secs_in = '0;
                  stop_in = 1'b0;
                  mode_in = stop_mid ? MODE_BLINK_END : MODE_PULSE;
               end else begin
                  secs_in = secs_ff - 1'b1;
               end
            end else begin
               phase_in = phase_next[PHASE_W-1:0];
            end
         end
         MODE_BLINK_END: begin
            if (phase_next >= (PHASE_W+1)'(blink_total)) begin
               interval_in = '0;
               mode_in     = MODE_SET;
               phase_in    = '0;
               stop_in     = 1'b0;
            end else begin
               phase_in = phase_next[PHASE_W-1:0];
            end
         end
         default: begin
            mode_in  = MODE_PICK;
            phase_in = '0;
         end
      endcase
   end

   // outputs
   always_comb begin
      shutter_q = (mode_ff == MODE_PULSE);
      led_q     = btn.qual;
      if ((mode_ff == MODE_BLINK_START) || (mode_ff == MODE_BLINK_END)) begin
         if (phase_ff >= PHASE_W'(cfg.blink_half_ticks)) begin
            led_q = 1'b1;
         end
      end
   end

   assign result.shutter_out     = shutter_q;
   assign result.led_out         = led_q;
   assign result.mode_now        = mode_ff;
   assign result.interval_now    = interval_in;
   assign result.unit_is_minutes = unit_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_PICK;
         unit_ff     <= 1'b0;
         interval_ff <= '0;
         phase_ff    <= '0;
         secs_ff     <= '0;
         stop_ff     <= 1'b0;
      end else if (step) begin
         mode_ff     <= mode_in;
         unit_ff     <= unit_in;
         interval_ff <= interval_in;
         phase_ff    <= phase_in;
         secs_ff     <= secs_in;
         stop_ff     <= stop_in;
      end
   end

endmodule

// ----- design/timelapse_intervalometer.sv -----
// timelapse_intervalometer: top level with settings registers, item registers
// depends on tli_pkg, tli_debounce, tli_ctrl
`timescale 1ns / 1ps

// Each accepted item is one tick carrying three button levels; each tick
// produces exactly one result item. An item is captured in an input register,
// processed by the debouncers and the mode sequencer, and lands
// in a result register, so the block sustains one item per clock while
// rsp_ready is high; a low rsp_ready stalls the flow. Settings registers
// (csr_index 0 debounce, 1 shutter, 2 blink half, 3 ticks per second) are
// always ready and should only be written while no items are in flight.

module timelapse_intervalometer #(
   parameter int unsigned MINUTE_SECONDS = tli_pkg::MINUTE_SECONDS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  tli_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output tli_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tli_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tli_pkg::CSR_DATA_W-1:0] csr_data
);
   import tli_pkg::*;

   cfg_type cfg_ff;
   logic    in_valid_ff;
   req_type in_data_ff;
   logic    out_valid_ff;
   rsp_type out_data_ff;
   logic    step;
   btn_type btn;
   rsp_type result;
   logic    qual_first, qual_second, qual_start;

   assign csr_ready = 1'b1;
   assign step      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks   <= DEBOUNCE_RST;
         cfg_ff.shutter_ticks    <= SHUTTER_RST;
         cfg_ff.blink_half_ticks <= BLINK_RST;
         cfg_ff.ticks_per_second <= TPS_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_DEBOUNCE: cfg_ff.debounce_ticks   <= csr_data[DEBOUNCE_W-1:0];
            CSR_SHUTTER:  cfg_ff.shutter_ticks    <= csr_data[SHUTTER_W-1:0];
            CSR_BLINK:    cfg_ff.blink_half_ticks <= csr_data[BLINK_W-1:0];
            CSR_TPS:      cfg_ff.ticks_per_second <= csr_data[TPS_W-1:0];
            default: ;
         endcase
      end
   end

   // input item register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   tli_debounce u_deb_first (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .press          (in_data_ff.press_first),
      .debounce_ticks (cfg_ff.debounce_ticks),
      .event_out      (btn.first),
      .qual_out       (qual_first)
   );

   tli_debounce u_deb_second (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .press          (in_data_ff.press_second),
      .debounce_ticks (cfg_ff.debounce_ticks),
      .event_out      (btn.second),
      .qual_out       (qual_second)
   );

   tli_debounce u_deb_start (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .press          (in_data_ff.press_start),
      .debounce_ticks (cfg_ff.debounce_ticks),
      .event_out      (btn.start),
      .qual_out       (qual_start)
   );

   assign btn.qual = qual_first | qual_second | qual_start;

   tli_ctrl #(
      .MINUTE_SECONDS (MINUTE_SECONDS)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .btn    (btn),
      .cfg    (cfg_ff),
      .result (result)
   );

   // result item register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_ready) begin
         out_valid_ff <= step;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_data_ff <= result;
      end
   end

endmodule
